// File: rtl/msc_pkg.sv
`default_nettype none

package msc_pkg;

  localparam int VW = 32;            // position / velocity word
  localparam int FW = 31;            // follow limit width
  localparam int MOTORS = 16;
  localparam int MIW = $clog2(MOTORS);
  localparam int MODEW = 8;
  localparam int PHW = 2;
  localparam int CHECKS = 12;
  localparam int FCW = 4;
  localparam int CIW = 3;            // config index width

  // difference and scaled-difference widths
  localparam int D1W = VW + 1;       // first differences, follow gaps
  localparam int D2W = VW + 3;       // second difference
  localparam int SCW = 10;           // bits added by a times-1000 step
  localparam int K1W = D1W + SCW;
  localparam int K2W = D2W + SCW;
  localparam int KKW = K2W + SCW;

  // 1000 = 2^10 - 2^4 - 2^3
  localparam int SH_HI = 10;
  localparam int SH_A = 4;
  localparam int SH_B = 3;

  localparam logic [MODEW-1:0] OPM_POS = MODEW'(8);
  localparam logic [MODEW-1:0] DPM_VEL = MODEW'(9);
  localparam logic [PHW-1:0] PHASE_LATER = PHW'(3);

  localparam logic [FCW-1:0] FC_NONE = '0;

  // check positions in the fault-code order (bit k is code k+1)
  localparam int CK_POS_MAX = 0;
  localparam int CK_POS_MIN = 1;
  localparam int CK_POS_STEP = 2;
  localparam int CK_POS_STEP_START = 3;
  localparam int CK_POS_D2 = 4;
  localparam int CK_POS_D2_START = 5;
  localparam int CK_POS_FOLLOW = 6;
  localparam int CK_VEL_MAX = 7;
  localparam int CK_VEL_MIN = 8;
  localparam int CK_VEL_STEP = 9;
  localparam int CK_VEL_STEP_START = 10;
  localparam int CK_VEL_FOLLOW = 11;

  typedef enum logic [CIW-1:0] {
    REG_POS_UPPER  = 3'd0,
    REG_POS_LOWER  = 3'd1,
    REG_VEL_UPPER  = 3'd2,
    REG_VEL_LOWER  = 3'd3,
    REG_ACC_UPPER  = 3'd4,
    REG_ACC_LOWER  = 3'd5,
    REG_POS_FOLLOW = 3'd6,
    REG_VEL_FOLLOW = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [VW-1:0] pos_upper_limit;
    logic signed [VW-1:0] pos_lower_limit;
    logic signed [VW-1:0] vel_upper_limit;
    logic signed [VW-1:0] vel_lower_limit;
    logic signed [VW-1:0] acc_upper_limit;
    logic signed [VW-1:0] acc_lower_limit;
    logic [FW-1:0]        pos_follow_limit;
    logic [FW-1:0]        vel_follow_limit;
  } cfg_t;

  // input item, first field in the highest bits
  typedef struct packed {
    logic signed [VW-1:0] act_velocity;
    logic signed [VW-1:0] cmd_velocity;
    logic signed [VW-1:0] act_position;
    logic signed [VW-1:0] cmd_position;
    logic [CHECKS-1:0]    check_disable;
    logic [PHW-1:0]       command_phase;
    logic [MODEW-1:0]     display_mode;
    logic [MODEW-1:0]     operation_mode;
    logic [MIW-1:0]       motor_index;
  } item_t;

  localparam int IN_BITS = $bits(item_t);
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [MIW-1:0] echo_motor;
    logic [FCW-1:0] fault_code;
    logic           fault;
  } res_t;

  localparam int OUT_BITS = $bits(res_t);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // per-item control carried down the pipe
  typedef struct packed {
    logic [MIW-1:0]    motor;
    logic [PHW-1:0]    phase;
    logic [CHECKS-1:0] check_disable;
    logic              pos_en;
    logic              vel_en;
  } ctl_t;

  // check results, filled in as the item moves along
  typedef struct packed {
    logic pos_max;
    logic pos_min;
    logic pos_step;
    logic pos_follow;
    logic vel_max;
    logic vel_min;
    logic vel_step;
    logic vel_follow;
  } flag_t;

  typedef struct packed {
    ctl_t                  ctl;
    flag_t                 fl;
    logic signed [D1W-1:0] d1;
    logic signed [D2W-1:0] d2;
    logic signed [D1W-1:0] dv;
    logic signed [D1W-1:0] ep;
    logic signed [D1W-1:0] ev;
  } diff_t;

  typedef struct packed {
    ctl_t                  ctl;
    flag_t                 fl;
    logic signed [K1W-1:0] d1k;
    logic signed [K2W-1:0] d2k;
    logic signed [K1W-1:0] dvk;
  } prod_t;

  typedef struct packed {
    ctl_t                  ctl;
    flag_t                 fl;
    logic signed [KKW-1:0] d2kk;
  } band_t;

endpackage

`default_nettype wire

// File: rtl/msc_front.sv
`default_nettype none

module msc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire msc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire msc_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output msc_pkg::diff_t      out_data
);

  logic                 a_valid;
  msc_pkg::item_t       a_item;
  logic                 a_load;
  logic                 b_load;
  msc_pkg::diff_t       b_next;

  logic signed [msc_pkg::VW-1:0] hist_pos  [msc_pkg::MOTORS];
  logic signed [msc_pkg::VW-1:0] hist_pos2 [msc_pkg::MOTORS];
  logic signed [msc_pkg::VW-1:0] hist_vel  [msc_pkg::MOTORS];

  logic signed [msc_pkg::VW-1:0] hp;
  logic signed [msc_pkg::VW-1:0] hpp;
  logic signed [msc_pkg::VW-1:0] hv;

  assign b_load = !out_valid || out_ready;
  assign a_load = !a_valid || b_load;
  assign in_ready = a_load;

  // history of the motor now in the input register; earlier items have
  // already written theirs on leaving this stage
  assign hp  = hist_pos[a_item.motor_index];
  assign hpp = hist_pos2[a_item.motor_index];
  assign hv  = hist_vel[a_item.motor_index];

  always_comb begin
    b_next = '0;
    b_next.ctl.motor = a_item.motor_index;
    b_next.ctl.phase = a_item.command_phase;
    b_next.ctl.check_disable = a_item.check_disable;
    b_next.ctl.pos_en = (a_item.operation_mode == msc_pkg::OPM_POS);
    b_next.ctl.vel_en = (a_item.display_mode == msc_pkg::DPM_VEL);
    b_next.fl.pos_max = $signed(a_item.cmd_position) > $signed(cfg.pos_upper_limit);
    b_next.fl.pos_min = $signed(a_item.cmd_position) < $signed(cfg.pos_lower_limit);
    b_next.fl.vel_max = $signed(a_item.cmd_velocity) > $signed(cfg.vel_upper_limit);
    b_next.fl.vel_min = $signed(a_item.cmd_velocity) < $signed(cfg.vel_lower_limit);
    b_next.d1 = msc_pkg::D1W'($signed(a_item.cmd_position)) - msc_pkg::D1W'(hp);
    b_next.d2 = msc_pkg::D2W'($signed(a_item.cmd_position)) + msc_pkg::D2W'(hpp)
              - (msc_pkg::D2W'(hp) <<< 1);
    b_next.dv = msc_pkg::D1W'($signed(a_item.cmd_velocity)) - msc_pkg::D1W'(hv);
    b_next.ep = msc_pkg::D1W'($signed(a_item.cmd_position))
              - msc_pkg::D1W'($signed(a_item.act_position));
    b_next.ev = msc_pkg::D1W'($signed(a_item.cmd_velocity))
              - msc_pkg::D1W'($signed(a_item.act_velocity));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < msc_pkg::MOTORS; i++) begin
        hist_pos[i] <= '0;
        hist_pos2[i] <= '0;
        hist_vel[i] <= '0;
      end
    end else begin
      if (a_load) begin
        a_valid <= in_valid;
      end
      if (b_load) begin
        out_valid <= a_valid;
      end
      // history moves on even when a check fails
      if (a_valid && b_load) begin
        hist_pos2[a_item.motor_index] <= hp;
        hist_pos[a_item.motor_index] <= a_item.cmd_position;
        hist_vel[a_item.motor_index] <= a_item.cmd_velocity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && in_valid) begin
      a_item <= in_item;
    end
    if (b_load && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/msc_scale.sv
`default_nettype none

module msc_scale (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire msc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire msc_pkg::diff_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output msc_pkg::band_t      out_data
);

  logic                  c_valid;
  msc_pkg::prod_t        c_data;
  msc_pkg::prod_t        c_next;
  msc_pkg::band_t        d_next;
  logic                  c_load;
  logic                  d_load;

  logic signed [msc_pkg::K1W-1:0] d1_x;
  logic signed [msc_pkg::K2W-1:0] d2_x;
  logic signed [msc_pkg::K1W-1:0] dv_x;
  logic signed [msc_pkg::KKW-1:0] d2k_x;
  logic [msc_pkg::D1W-1:0]        ep_mag;
  logic [msc_pkg::D1W-1:0]        ev_mag;

  assign d_load = !out_valid || out_ready;
  assign c_load = !c_valid || d_load;
  assign in_ready = c_load;

  assign d1_x = msc_pkg::K1W'($signed(in_data.d1));
  assign d2_x = msc_pkg::K2W'($signed(in_data.d2));
  assign dv_x = msc_pkg::K1W'($signed(in_data.dv));
  assign d2k_x = msc_pkg::KKW'($signed(c_data.d2k));

  assign ep_mag = in_data.ep[msc_pkg::D1W-1] ? msc_pkg::D1W'(-in_data.ep)
                                             : msc_pkg::D1W'(in_data.ep);
  assign ev_mag = in_data.ev[msc_pkg::D1W-1] ? msc_pkg::D1W'(-in_data.ev)
                                             : msc_pkg::D1W'(in_data.ev);

  // scale the differences by 1000 so the bounds need no division:
  // d > floor(L/1000) is the same as 1000*d > L
  always_comb begin
    c_next.ctl = in_data.ctl;
    c_next.fl = in_data.fl;
    c_next.fl.pos_follow = ep_mag > msc_pkg::D1W'(cfg.pos_follow_limit);
    c_next.fl.vel_follow = ev_mag > msc_pkg::D1W'(cfg.vel_follow_limit);
    c_next.d1k = (d1_x <<< msc_pkg::SH_HI) - (d1_x <<< msc_pkg::SH_A)
               - (d1_x <<< msc_pkg::SH_B);
    c_next.d2k = (d2_x <<< msc_pkg::SH_HI) - (d2_x <<< msc_pkg::SH_A)
               - (d2_x <<< msc_pkg::SH_B);
    c_next.dvk = (dv_x <<< msc_pkg::SH_HI) - (dv_x <<< msc_pkg::SH_A)
               - (dv_x <<< msc_pkg::SH_B);
  end

  always_comb begin
    d_next.ctl = c_data.ctl;
    d_next.fl = c_data.fl;
    d_next.fl.pos_step =
        ($signed(c_data.d1k) > msc_pkg::K1W'($signed(cfg.vel_upper_limit)))
     || ($signed(c_data.d1k) < msc_pkg::K1W'($signed(cfg.vel_lower_limit)));
    d_next.fl.vel_step =
        ($signed(c_data.dvk) > msc_pkg::K1W'($signed(cfg.acc_upper_limit)))
     || ($signed(c_data.dvk) < msc_pkg::K1W'($signed(cfg.acc_lower_limit)));
    // second difference against 1e-6 of the limit: one more times-1000
    d_next.d2kk = (d2k_x <<< msc_pkg::SH_HI) - (d2k_x <<< msc_pkg::SH_A)
                - (d2k_x <<< msc_pkg::SH_B);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_load) begin
        c_valid <= in_valid;
      end
      if (d_load) begin
        out_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load && in_valid) begin
      c_data <= c_next;
    end
    if (d_load && c_valid) begin
      out_data <= d_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/msc_judge.sv
`default_nettype none

module msc_judge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire msc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire msc_pkg::band_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output msc_pkg::res_t       out_data
);

  logic                          pos_d2;
  logic                          ph_ge2;
  logic                          ph_later;
  logic                          pe;
  logic                          ve;
  logic [msc_pkg::CHECKS-1:0]    fail;
  logic [msc_pkg::CHECKS-1:0]    active;
  logic [msc_pkg::FCW-1:0]       code;
  msc_pkg::res_t                 res_next;

  assign in_ready = !out_valid || out_ready;

  assign pos_d2 =
      ($signed(in_data.d2kk) > msc_pkg::KKW'($signed(cfg.acc_upper_limit)))
   || ($signed(in_data.d2kk) < msc_pkg::KKW'($signed(cfg.acc_lower_limit)));

  // phase zero counts as a first tick
  assign ph_ge2 = in_data.ctl.phase[msc_pkg::PHW-1];
  assign ph_later = (in_data.ctl.phase == msc_pkg::PHASE_LATER);
  assign pe = in_data.ctl.pos_en;
  assign ve = in_data.ctl.vel_en;

  always_comb begin
    fail = '0;
    fail[msc_pkg::CK_POS_MAX] = pe && in_data.fl.pos_max;
    fail[msc_pkg::CK_POS_MIN] = pe && in_data.fl.pos_min;
    fail[msc_pkg::CK_POS_STEP] = pe && ph_ge2 && in_data.fl.pos_step;
    fail[msc_pkg::CK_POS_STEP_START] = pe && !ph_ge2 && in_data.fl.pos_step;
    fail[msc_pkg::CK_POS_D2] = pe && ph_later && pos_d2;
    fail[msc_pkg::CK_POS_D2_START] = pe && !ph_later && pos_d2;
    fail[msc_pkg::CK_POS_FOLLOW] = pe && in_data.fl.pos_follow;
    fail[msc_pkg::CK_VEL_MAX] = ve && in_data.fl.vel_max;
    fail[msc_pkg::CK_VEL_MIN] = ve && in_data.fl.vel_min;
    fail[msc_pkg::CK_VEL_STEP] = ve && ph_ge2 && in_data.fl.vel_step;
    fail[msc_pkg::CK_VEL_STEP_START] = ve && !ph_ge2 && in_data.fl.vel_step;
    fail[msc_pkg::CK_VEL_FOLLOW] = ve && in_data.fl.vel_follow;
  end

  assign active = fail & ~in_data.ctl.check_disable;

  // lowest failing check wins
  always_comb begin
    code = msc_pkg::FC_NONE;
    for (int k = msc_pkg::CHECKS - 1; k >= 0; k--) begin
      if (active[k]) begin
        code = msc_pkg::FCW'(k + 1);
      end
    end
  end

  always_comb begin
    res_next.echo_motor = in_data.ctl.motor;
    res_next.fault_code = code;
    res_next.fault = (code != msc_pkg::FC_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/motion_command_safety_checker_top.sv
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: one motor sample
// m_*       out  m_tvalid/m_tready   m_tdata: fault result
// cfg_*     in   cfg_wr_en           cfg_index, cfg_wdata: limit registers
//
// one item per clock sustained while m_* is ready; a result passes through
// the five register stages (input, difference, scale, band, output) with
// the history read in the difference stage
// reset (rst, synchronous) empties the pipe, clears every motor's history
// to zero and sets the limits to their widest values
// a stalled m_* holds only the stages that are full; empty stages still fill
`default_nettype none

module motion_command_safety_checker_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // motor_index, operation_mode, display_mode, command_phase,
  // check_disable, cmd_position, act_position, cmd_velocity, act_velocity
  input  wire logic [msc_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // fault, fault_code, echo_motor
  output logic [msc_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [msc_pkg::CIW-1:0]             cfg_index,
  input  wire logic [msc_pkg::VW-1:0]              cfg_wdata
);

  msc_pkg::cfg_t  cfg;
  msc_pkg::item_t s_item;
  msc_pkg::diff_t diff_data;
  msc_pkg::band_t band_data;
  msc_pkg::res_t  res;
  logic           diff_valid;
  logic           diff_ready;
  logic           band_valid;
  logic           band_ready;

  assign s_item = msc_pkg::item_t'(s_tdata[msc_pkg::IN_BITS-1:0]);
  assign m_tdata = msc_pkg::OUT_TDATA_W'(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_upper_limit <= {1'b0, {(msc_pkg::VW-1){1'b1}}};
      cfg.pos_lower_limit <= {1'b1, {(msc_pkg::VW-1){1'b0}}};
      cfg.vel_upper_limit <= {1'b0, {(msc_pkg::VW-1){1'b1}}};
      cfg.vel_lower_limit <= {1'b1, {(msc_pkg::VW-1){1'b0}}};
      cfg.acc_upper_limit <= {1'b0, {(msc_pkg::VW-1){1'b1}}};
      cfg.acc_lower_limit <= {1'b1, {(msc_pkg::VW-1){1'b0}}};
      cfg.pos_follow_limit <= '1;
      cfg.vel_follow_limit <= '1;
    end else if (cfg_wr_en) begin
      case (msc_pkg::reg_idx_t'(cfg_index))
        msc_pkg::REG_POS_UPPER:  cfg.pos_upper_limit <= cfg_wdata;
        msc_pkg::REG_POS_LOWER:  cfg.pos_lower_limit <= cfg_wdata;
        msc_pkg::REG_VEL_UPPER:  cfg.vel_upper_limit <= cfg_wdata;
        msc_pkg::REG_VEL_LOWER:  cfg.vel_lower_limit <= cfg_wdata;
        msc_pkg::REG_ACC_UPPER:  cfg.acc_upper_limit <= cfg_wdata;
        msc_pkg::REG_ACC_LOWER:  cfg.acc_lower_limit <= cfg_wdata;
        msc_pkg::REG_POS_FOLLOW: cfg.pos_follow_limit <= cfg_wdata[msc_pkg::FW-1:0];
        msc_pkg::REG_VEL_FOLLOW: cfg.vel_follow_limit <= cfg_wdata[msc_pkg::FW-1:0];
        default: begin
        end
      endcase
    end
  end

  msc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_data  (diff_data)
  );

  msc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_data   (diff_data),
    .out_valid (band_valid),
    .out_ready (band_ready),
    .out_data  (band_data)
  );

  msc_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (band_valid),
    .in_ready  (band_ready),
    .in_data   (band_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

endmodule

`default_nettype wire
